// File: src/lpht_pkg.sv
// package for the linear probe hash table: sizes, codes and entry layout
package lpht_pkg;
  localparam int Capacity = 1024;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int HashW = 64;
  localparam int WordW = 32;
  localparam int EntW = 2 + HashW + 2 * WordW;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  localparam logic [1:0] MODE_READ = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic occ;
    logic col;
    logic [HashW-1:0] hash;
    logic [WordW-1:0] key;
    logic [WordW-1:0] size;
  } entry_t;
endpackage

// File: src/lpht_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
module lpht_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: src/lpht_mod.sv
// iterative 64 bit by 11 bit remainder, one quotient bit per cycle
module lpht_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [63:0]                dividend,
  input  logic [lpht_pkg::CntW-1:0]  divisor,
  output logic                       done,
  output logic [lpht_pkg::CntW-1:0]  rem
);
  import lpht_pkg::*;
  logic [63:0] q_r;
  logic [CntW:0] rem_r;
  logic [6:0] cnt_r;
  logic busy_r;
  logic [CntW:0] sh;
  logic [CntW:0] dv;
  always_comb begin
    sh = {rem_r[CntW-1:0], q_r[63]};
    dv = {1'b0, divisor};
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
        done <= 1'b0;
        q_r <= dividend;
        rem_r <= '0;
        cnt_r <= '0;
      end else if (busy_r) begin
        q_r <= {q_r[62:0], 1'b0};
        rem_r <= (sh >= dv) ? sh - dv : sh;
        cnt_r <= cnt_r + 7'd1;
        done <= (cnt_r == 7'd63);
        if (cnt_r == 7'd63) busy_r <= 1'b0;
      end else begin
        done <= 1'b0;
      end
    end
  end
  assign rem = rem_r[CntW-1:0];
endmodule

// File: src/linear_probe_hash_table_core.sv
// top level of the linear probe hash table
// requests enter on in_valid/in_stall, one result leaves on out_valid/out_stall.
// cfg_valid/cfg_ready writes table_size (0 acts as 1, larger than capacity clips).
// one request is processed at a time; in_stall is high while busy or output full.
// after reset a clearing pass clears all slots; no request is taken during it.
// insert, lookup and remove: the remainder is computed first, then each probed slot is
// read from the registered memory and then checked, plus a second walk on insert to mark
// shared hashes; read slot reads the selected slot directly, with no remainder step.
// the result register holds until out_stall is low; a new request is taken
// only after the result leaves.
module linear_probe_hash_table_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [63:0]                   in_key_hash,
  input  logic [31:0]                   in_key_word,
  input  logic [31:0]                   in_byte_size,
  input  logic [9:0]                    in_slot_select,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_status,
  output logic [9:0]                    out_slot_index,
  output logic [31:0]                   out_read_key,
  output logic [31:0]                   out_read_size,
  output logic [10:0]                   out_live_entries,
  output logic [31:0]                   out_collisions_seen,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [10:0]                   cfg_table_size
);
  import lpht_pkg::*;
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_MOD, S_RD, S_CHK, S_MARK_RD, S_MARK_CHK, S_PUT, S_RS_RD, S_RS_CHK,
    S_OUT
  } state_t;
  state_t st_r;
  logic [10:0] tsize_r;
  logic [1:0] mode_r;
  logic [63:0] hash_r;
  logic [31:0] key_r, bsz_r;
  logic [IdxW-1:0] idx_r, start_r, free_r;
  logic [CntW-1:0] n_r, passed_r;
  logic shared_r;
  logic [CntW-1:0] cnt_r;
  logic [31:0] coll_r;
  logic we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t wdata, rd;
  logic [CntW-1:0] asize, rem;
  logic mdone, mstart;
  logic [IdxW-1:0] nxt_idx;

  always_comb begin
    asize = (tsize_r == 11'd0) ? CntW'(1) :
            ({1'b0, tsize_r} > 12'(Capacity)) ? CntW'(Capacity) : CntW'(tsize_r);
    nxt_idx = ({1'b0, idx_r} + 1'b1 >= (IdxW+1)'(asize)) ? '0 : idx_r + 1'b1;
  end

  lpht_mod u_mod (.clk, .rst_n, .start(mstart), .dividend(in_key_hash), .divisor(asize),
                  .done(mdone), .rem);
  lpht_ram #(.Width(EntW), .Depth(Capacity)) u_ram (.clk, .we, .waddr, .wdata,
                                                    .raddr, .rdata(rd));

  assign in_stall = (st_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign mstart = (st_r == S_IDLE) && in_valid && in_mode != MODE_READ;
  assign out_live_entries = cnt_r;
  assign out_collisions_seen = coll_r;

  always_comb begin
    we = 1'b0;
    waddr = idx_r;
    wdata = rd;
    raddr = idx_r;
    if (st_r == S_IDLE) raddr = in_slot_select;
    case (st_r)
      S_CLR: begin
        we = 1'b1;
        wdata = '0;
      end
      S_MARK_CHK: if (rd.hash == hash_r) begin
        we = 1'b1;
        wdata.col = 1'b1;
      end
      S_PUT: begin
        we = 1'b1;
        waddr = free_r;
        wdata = '{occ: 1'b1, col: shared_r, hash: hash_r, key: key_r, size: bsz_r};
      end
      S_CHK: if (mode_r == MODE_REMOVE && rd.occ && rd.hash == hash_r &&
                 (!rd.col || rd.key == key_r)) begin
        we = 1'b1;
        wdata.occ = 1'b0;
        wdata.col = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      idx_r <= '0;
      tsize_r <= 11'd1024;
      cnt_r <= '0;
      coll_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) tsize_r <= cfg_table_size;
      case (st_r)
        S_CLR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == IdxW'(Capacity - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin
          mode_r <= in_mode;
          hash_r <= in_key_hash;
          key_r <= in_key_word;
          bsz_r <= in_byte_size;
          out_read_key <= '0;
          out_read_size <= '0;
          out_slot_index <= '0;
          out_status <= ST_MISS;
          shared_r <= 1'b0;
          n_r <= '0;
          passed_r <= '0;
          idx_r <= in_slot_select;
          st_r <= (in_mode == MODE_READ) ? S_RS_RD : S_MOD;
        end
        S_MOD: if (mdone) begin
          idx_r <= rem[IdxW-1:0];
          start_r <= rem[IdxW-1:0];
          st_r <= S_RD;
        end
        S_RD: st_r <= S_CHK;
        S_CHK: begin
          if (mode_r == MODE_INSERT) begin
            if (!rd.occ) begin
              free_r <= idx_r;
              idx_r <= start_r;
              n_r <= '0;
              st_r <= (passed_r == '0) ? S_PUT : S_MARK_RD;
            end else if (n_r + 1'b1 == asize) begin
              out_status <= ST_FULL;
              st_r <= S_OUT;
            end else begin
              passed_r <= passed_r + 1'b1;
              n_r <= n_r + 1'b1;
              idx_r <= nxt_idx;
              st_r <= S_RD;
            end
          end else begin
            if (!rd.occ) st_r <= S_OUT;
            else if (rd.hash == hash_r && (!rd.col || rd.key == key_r)) begin
              out_status <= ST_OK;
              out_slot_index <= idx_r;
              if (mode_r == MODE_REMOVE && cnt_r != '0) cnt_r <= cnt_r - 1'b1;
              st_r <= S_OUT;
            end else if (n_r + 1'b1 == asize) st_r <= S_OUT;
            else begin
              n_r <= n_r + 1'b1;
              idx_r <= nxt_idx;
              st_r <= S_RD;
            end
          end
        end
        S_MARK_RD: st_r <= S_MARK_CHK;
        S_MARK_CHK: begin
          if (rd.hash == hash_r) begin
            shared_r <= 1'b1;
            if (coll_r != '1) coll_r <= coll_r + 1'b1;
          end
          n_r <= n_r + 1'b1;
          idx_r <= nxt_idx;
          st_r <= (n_r + 1'b1 == passed_r) ? S_PUT : S_MARK_RD;
        end
        S_PUT: begin
          cnt_r <= cnt_r + 1'b1;
          out_status <= ST_OK;
          out_slot_index <= free_r;
          st_r <= S_OUT;
        end
        S_RS_RD: st_r <= S_RS_CHK;
        S_RS_CHK: begin
          out_slot_index <= idx_r;
          out_read_key <= rd.key;
          out_read_size <= rd.size;
          out_status <= rd.occ ? ST_OK : ST_MISS;
          st_r <= S_OUT;
        end
        S_OUT: begin
          out_valid <= !(out_valid && !out_stall);
          if (out_valid && !out_stall) st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_live_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(Capacity)) else $error("entry count beyond capacity");
  a_out_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> st_r == S_OUT) else $error("result outside output state");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> in_stall) else $error("request accepted while busy");
endmodule
